>>> design/rdc_pkg.sv
// Shared types, constants and helper functions of the radix digit converter.
`default_nettype none

package rdc_pkg;

  // Result digits before the result saturates
  localparam int MAX_OUT_DIGITS = 19;

  // Field and datapath widths
  localparam int RADIX_W     = 4;
  localparam int WORD_W      = 31;
  localparam int VALUE_W     = 34;   // holds any weighted input value, below 10^10
  localparam int RESULT_W    = 64;
  localparam int COUNT_W     = $clog2(MAX_OUT_DIGITS + 1);
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = RADIX_W;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_RADIX = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RADIX = CFG_INDEX_W'(1);

  // Register reset values and legal radix range
  localparam logic [RADIX_W-1:0] SOURCE_RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] TARGET_RADIX_RESET = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MIN          = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX          = RADIX_W'(10);

  // Divide by ten: exact for any 32-bit dividend
  localparam logic [31:0] RECIP_TEN       = 32'hCCCC_CCCD;
  localparam int          RECIP_TEN_SHIFT = 35;

  // Divide by a target radix: ceiling reciprocals scaled by 2^RECIP_SHIFT
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 32;
  // Quotient estimate overshoots by at most this many steps
  localparam int CORR_STEPS  = 4;

  // Depth of the queue between front and back (power of two)
  localparam int FIFO_DEPTH = 2;

  // One word handed from front to back
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } rdc_item_t;

  // Clamp a radix register into the legal range
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

  // Ceiling of 2^32 / d for the legal radices
  function automatic logic [RECIP_W-1:0] radix_recip(input logic [RADIX_W-1:0] d);
    case (d)
      4'd2:    return 32'd2147483648;
      4'd3:    return 32'd1431655766;
      4'd4:    return 32'd1073741824;
      4'd5:    return 32'd858993460;
      4'd6:    return 32'd715827883;
      4'd7:    return 32'd613566757;
      4'd8:    return 32'd536870912;
      4'd9:    return 32'd477218589;
      4'd10:   return 32'd429496730;
      default: return 32'd2147483648;
    endcase
  endfunction

  // All-nines word of MAX_OUT_DIGITS digits
  function automatic logic [RESULT_W-1:0] saturate_word();
    logic [RESULT_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_OUT_DIGITS; i++) begin
      r = r * RESULT_W'(10) + RESULT_W'(9);
    end
    return r;
  endfunction

  localparam logic [RESULT_W-1:0] SAT_WORD = saturate_word();

endpackage

`default_nettype wire

>>> design/rdc_front.sv
// Front end: accepts a word and weights its decimal digits by powers of the source radix.
`default_nettype none

module rdc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [rdc_pkg::WORD_W-1:0]    digit_word,
  input  logic [rdc_pkg::RADIX_W-1:0]   source_radix,
  input  logic [rdc_pkg::RADIX_W-1:0]   target_radix,
  output logic                          item_push,
  input  logic                          item_full,
  output rdc_pkg::rdc_item_t            item
);
  import rdc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIG  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  localparam int PROD_W = WORD_W + 32;

  logic [1:0]         state;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  quot;
  logic [VALUE_W-1:0] value;
  logic [VALUE_W-1:0] weight;
  logic [RADIX_W-1:0] src;
  logic [RADIX_W-1:0] dst;

  logic [PROD_W-1:0]  prod;
  logic [6:0]         ten_quot;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] term;

  // Split off the lowest decimal digit: quotient by reciprocal, digit from low bits
  assign prod     = PROD_W'(word) * PROD_W'(RECIP_TEN);
  assign ten_quot = {quot[3:0], 3'b000} + {2'b00, quot[3:0], 1'b0};
  assign digit    = word[3:0] - ten_quot[3:0];
  assign term     = VALUE_W'(digit) * weight;

  assign full      = (state != ST_IDLE);
  assign item_push = (state == ST_PUSH) && !item_full;
  assign item      = '{value: value, radix: dst};

  // Sequence each digit through the multiply state and then the digit state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (push) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIG;
        end
        ST_DIG: begin
          if (quot == '0) begin
            state <= ST_PUSH;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_PUSH: begin
          if (!item_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        word   <= digit_word;
        value  <= '0;
        weight <= VALUE_W'(1);
        src    <= clamp_radix(source_radix);
        dst    <= clamp_radix(target_radix);
      end
      ST_MUL: begin
        quot <= WORD_W'(prod[PROD_W-1:RECIP_TEN_SHIFT]);
      end
      ST_DIG: begin
        value  <= value + term;
        weight <= weight * VALUE_W'(src);
        word   <= quot;
      end
      default: begin
        word <= word;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/rdc_fifo.sv
// Short queue that decouples the front end from the back end.
`default_nettype none

module rdc_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rdc_pkg::rdc_item_t  push_item,
  input  logic                pop,
  output logic                empty,
  output rdc_pkg::rdc_item_t  pop_item
);
  import rdc_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  rdc_item_t         slots [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign full     = (fill == CNT_W'(FIFO_DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> design/rdc_back.sv
// Back end: splits the value into target-radix digits and packs them as decimal digits.
`default_nettype none

module rdc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_empty,
  output logic                          item_pop,
  input  rdc_pkg::rdc_item_t            item,
  output logic                          empty,
  input  logic                          pop,
  output logic [rdc_pkg::RESULT_W-1:0]  converted_word,
  output logic                          overflow
);
  import rdc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_FIX  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int PROD_W = VALUE_W + RECIP_W;
  localparam int ADJ_W  = $clog2(CORR_STEPS + 1);

  logic [2:0]          state;
  logic [VALUE_W-1:0]  value;
  logic [RADIX_W-1:0]  radix;
  logic [VALUE_W-1:0]  quot_est;
  logic [RADIX_W-1:0]  rem;
  logic [COUNT_W-1:0]  count;
  logic [RESULT_W-1:0] pow10;
  logic [RESULT_W-1:0] result;
  logic                ovf;
  logic                out_full;
  logic [RESULT_W-1:0] out_word;
  logic                out_ovf;

  logic [PROD_W-1:0]   prod;
  logic [7:0]          fix_diff;
  logic [7:0]          fix_cand;
  logic [RADIX_W-1:0]  fix_rem;
  logic [ADJ_W-1:0]    fix_adj;
  logic [VALUE_W-1:0]  fix_quot;
  logic [COUNT_W-1:0]  count_inc;
  logic [RESULT_W-1:0] acc_term;
  logic                out_free;

  // Quotient estimate by reciprocal, never below the true quotient
  assign prod = PROD_W'(value) * PROD_W'(radix_recip(radix));

  // Correct the estimate: the remainder fits in the low byte
  always_comb begin
    fix_diff = value[7:0] - 8'(quot_est[7:0] * 8'(radix));
    fix_cand = fix_diff;
    fix_rem  = fix_diff[RADIX_W-1:0];
    fix_adj  = '0;
    for (int k = CORR_STEPS; k >= 0; k--) begin
      fix_cand = fix_diff + 8'(k) * 8'(radix);
      if (!fix_cand[7]) begin
        fix_rem = fix_cand[RADIX_W-1:0];
        fix_adj = ADJ_W'(k);
      end
    end
  end

  assign fix_quot  = quot_est - VALUE_W'(fix_adj);
  assign count_inc = count + 1'b1;
  assign acc_term  = RESULT_W'(rem) * pow10;
  assign out_free  = !out_full || pop;

  assign item_pop       = (state == ST_IDLE) && !item_empty;
  assign empty          = !out_full;
  assign converted_word = out_word;
  assign overflow       = out_ovf;

  // Sequence each target digit through the multiply state and then the fix state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!item_empty) begin
            state <= (item.value == '0) ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_FIX;
        end
        ST_FIX: begin
          if (fix_quot == '0) begin
            state <= ST_ACC;
          end else if (count_inc == COUNT_W'(MAX_OUT_DIGITS)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_ACC: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Digit datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        value  <= item.value;
        radix  <= item.radix;
        count  <= '0;
        pow10  <= RESULT_W'(1);
        result <= '0;
        rem    <= '0;
        ovf    <= 1'b0;
      end
      ST_MUL: begin
        quot_est <= prod[PROD_W-1:RECIP_SHIFT];
        if (count != '0) begin
          result <= result + acc_term;
          pow10  <= (pow10 << 3) + (pow10 << 1);
        end
      end
      ST_FIX: begin
        rem   <= fix_rem;
        value <= fix_quot;
        count <= count_inc;
        if (fix_quot != '0 && count_inc == COUNT_W'(MAX_OUT_DIGITS)) begin
          ovf <= 1'b1;
        end
      end
      ST_ACC: begin
        result <= result + acc_term;
      end
      default: begin
        value <= value;
      end
    endcase
  end

  // Hold the finished word until it is popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_word <= ovf ? SAT_WORD : result;
      out_ovf  <= ovf;
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_full)
    else $error("result register not empty after reset");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |-> (fix_rem < radix))
    else $error("corrected remainder not below radix");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_ovf) |-> (out_word == SAT_WORD))
    else $error("overflow word not saturated");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (count <= COUNT_W'(MAX_OUT_DIGITS)))
    else $error("digit count beyond limit");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_free) |=> (state == ST_DONE))
    else $error("finished word dropped while result register full");

endmodule

`default_nettype wire

>>> design/radix_digit_converter_unit.sv
// Top level of the radix digit converter: configuration registers, front end, queue, back end.
//
// Usage:
//   Input queue side: drive digit_word and raise push; the word is taken at a rising
//   edge with push high and full low. Its decimal digits are read in the source radix.
//   Result queue side: while empty is low, converted_word and overflow show the oldest
//   result; raise pop to take it. Each input word gives exactly one result word.
//   Configuration: write source_radix (index 0) or target_radix (index 1) with
//   cfg_valid; cfg_ready is always high. Other indexes are dropped. Write only when idle.
// Sequencing:
//   The front end takes each decimal input digit (at most 10) through a multiply state,
//   its divide-by-ten reciprocal multiplier, and then a digit state, the weighting step.
//   The back end takes each target digit (at most 19) through a multiply state, its
//   reciprocal multiplier, and then a fix state, the remainder correction.
//   A two-word queue lets both ends run on different words at once, so the slower
//   of the two sets the pace of the unit while the result side keeps popping.
// Reset: rst (synchronous) empties the queue and the result register and restores
//   source_radix to 10 and target_radix to 2.
// Stalls: a finished result waits in the result register while the back end starts
//   the next word; when the receiver keeps it waiting, the queue and then full back up.
`default_nettype none

module radix_digit_converter_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [rdc_pkg::WORD_W-1:0]      digit_word,
  output logic                            empty,
  input  logic                            pop,
  output logic [rdc_pkg::RESULT_W-1:0]    converted_word,
  output logic                            overflow,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rdc_pkg::*;

  logic [RADIX_W-1:0] source_radix;
  logic [RADIX_W-1:0] target_radix;

  logic      front_push;
  logic      fifo_full;
  rdc_item_t front_item;
  logic      back_pop;
  logic      fifo_empty;
  rdc_item_t back_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_radix <= SOURCE_RADIX_RESET;
      target_radix <= TARGET_RADIX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE_RADIX: source_radix <= cfg_data;
        REG_TARGET_RADIX: target_radix <= cfg_data;
        default: begin
          source_radix <= source_radix;
        end
      endcase
    end
  end

  rdc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .digit_word   (digit_word),
    .source_radix (source_radix),
    .target_radix (target_radix),
    .item_push    (front_push),
    .item_full    (fifo_full),
    .item         (front_item)
  );

  rdc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .full      (fifo_full),
    .push_item (front_item),
    .pop       (back_pop),
    .empty     (fifo_empty),
    .pop_item  (back_item)
  );

  rdc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_empty     (fifo_empty),
    .item_pop       (back_pop),
    .item           (back_item),
    .empty          (empty),
    .pop            (pop),
    .converted_word (converted_word),
    .overflow       (overflow)
  );

endmodule

`default_nettype wire

>>> test/radix_digit_converter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_digit_converter_unit: directed table, then random traffic.

module radix_digit_converter_unit_tb;
  import rdc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_WORDS = 1930;
  localparam int MAX_GAP      = 5;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 120;
  localparam int MAX_REPORTS  = 100;
  localparam int N_DIRECTED   = 22;

  localparam logic [RESULT_W-1:0] ALL_NINES = 64'd9999999999999999999;

  typedef struct packed {
    logic [RESULT_W-1:0] converted;
    logic                ovf;
  } conversion_t;

  // One directed row: radix settings, word, and optionally a typed-in result
  typedef struct packed {
    logic [RADIX_W-1:0]  src;
    logic [RADIX_W-1:0]  dst;
    logic [WORD_W-1:0]   word;
    logic                known;
    logic [RESULT_W-1:0] want;
    logic                want_ovf;
  } vector_t;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   push       = 1'b0;
  logic                   full;
  logic [WORD_W-1:0]      digit_word = '0;
  logic                   empty;
  logic                   pop        = 1'b0;
  logic [RESULT_W-1:0]    converted_word;
  logic                   overflow;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Register copies as the block should hold them
  logic [RADIX_W-1:0] source_setting = SOURCE_RADIX_RESET;
  logic [RADIX_W-1:0] target_setting = TARGET_RADIX_RESET;

  conversion_t expected_conversions[$];
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  bit          burst_phase    = 1'b0;

  vector_t directed_vectors [N_DIRECTED] = '{
    '{4'd10, 4'd2,  31'd0,          1'b1, 64'd0,          1'b0},
    '{4'd10, 4'd2,  31'd5,          1'b1, 64'd101,        1'b0},
    '{4'd10, 4'd2,  31'd2147483647, 1'b1, ALL_NINES,      1'b1},
    '{4'd10, 4'd2,  31'd524287,     1'b0, 64'd0,          1'b0},
    '{4'd10, 4'd2,  31'd524288,     1'b0, 64'd0,          1'b0},
    '{4'd10, 4'd10, 31'd2147483647, 1'b1, 64'd2147483647, 1'b0},
    '{4'd10, 4'd10, 31'd0,          1'b1, 64'd0,          1'b0},
    '{4'd2,  4'd10, 31'd1111111111, 1'b1, 64'd1023,       1'b0},
    '{4'd2,  4'd10, 31'd1999999999, 1'b0, 64'd0,          1'b0},
    '{4'd0,  4'd15, 31'd101,        1'b1, 64'd5,          1'b0},
    '{4'd0,  4'd15, 31'd2147483647, 1'b0, 64'd0,          1'b0},
    '{4'd15, 4'd0,  31'd2147483647, 1'b0, 64'd0,          1'b0},
    '{4'd1,  4'd11, 31'd1010,       1'b0, 64'd0,          1'b0},
    '{4'd9,  4'd3,  31'd2147483647, 1'b0, 64'd0,          1'b0},
    '{4'd3,  4'd9,  31'd1,          1'b0, 64'd0,          1'b0},
    '{4'd2,  4'd2,  31'd1111111111, 1'b0, 64'd0,          1'b0},
    '{4'd10, 4'd3,  31'd1162261466, 1'b0, 64'd0,          1'b0},
    '{4'd10, 4'd3,  31'd1162261467, 1'b0, 64'd0,          1'b0},
    '{4'd5,  4'd7,  31'd1234567890, 1'b0, 64'd0,          1'b0},
    '{4'd8,  4'd9,  31'd2147483647, 1'b0, 64'd0,          1'b0},
    '{4'd10, 4'd9,  31'd1000000000, 1'b0, 64'd0,          1'b0},
    '{4'd4,  4'd2,  31'd333333333,  1'b0, 64'd0,          1'b0}
  };

  radix_digit_converter_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .digit_word     (digit_word),
    .empty          (empty),
    .pop            (pop),
    .converted_word (converted_word),
    .overflow       (overflow),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Clamp a register value into the usable radix range
  function automatic longint unsigned effective_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return longint'(RADIX_MIN);
    end
    if (r > RADIX_MAX) begin
      return longint'(RADIX_MAX);
    end
    return longint'(r);
  endfunction

  // Expected result word for one input word under the given register values
  function automatic conversion_t convert_radix_digits(input logic [WORD_W-1:0] w,
                                                       input logic [RADIX_W-1:0] src_reg,
                                                       input logic [RADIX_W-1:0] dst_reg);
    longint unsigned rest, value, weight, place, src, dst;
    int unsigned     digits;
    conversion_t     res;
    src    = effective_radix(src_reg);
    dst    = effective_radix(dst_reg);
    rest   = longint'(w);
    value  = 0;
    weight = 1;
    // weight each decimal digit by the next power of the source radix
    while (rest != 0) begin
      value  += (rest % 10) * weight;
      weight *= src;
      rest   /= 10;
    end
    // peel target-radix digits, least significant first, into decimal places
    res.converted = '0;
    place         = 1;
    digits        = 0;
    while (value != 0) begin
      if (digits < MAX_OUT_DIGITS) begin
        res.converted += (value % dst) * place;
        place         *= 10;
      end
      value /= dst;
      digits++;
    end
    res.ovf = (digits > MAX_OUT_DIGITS);
    if (res.ovf) begin
      res.converted = ALL_NINES;
    end
    return res;
  endfunction

  // Mostly legal radices, now and then any register value
  function automatic logic [RADIX_W-1:0] random_radix_setting();
    if ($urandom_range(0, 9) < 7) begin
      return RADIX_W'($urandom_range(int'(RADIX_MIN), int'(RADIX_MAX)));
    end
    return RADIX_W'($urandom_range(0, 2**RADIX_W - 1));
  endfunction

  // Mix of well-formed digit strings, short words, corner words and raw noise
  function automatic logic [WORD_W-1:0] random_digit_word(input logic [RADIX_W-1:0] src_reg);
    longint unsigned acc, src;
    int unsigned     n;
    acc = 0;
    src = effective_radix(src_reg);
    case ($urandom_range(0, 7))
      0, 1: return WORD_W'($urandom);
      2, 3, 4: begin
        // every decimal digit legal in the source radix
        n = $urandom_range(1, 9);
        repeat (n) acc = acc * 10 + $urandom_range(0, int'(src) - 1);
        return WORD_W'(acc);
      end
      5: return WORD_W'($urandom_range(0, 999));
      6: return WORD_W'($urandom_range(0, 99999));
      default: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [RESULT_W-1:0] got,
                                 input logic [RESULT_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: got %0d, want %0d", $time, field, got, want);
    end
  endtask

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [WORD_W-1:0] w, input conversion_t want);
    int unsigned gap;
    gap = burst_phase ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push       = 1'b1;
    digit_word = w;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    expected_conversions.insert(expected_conversions.size(), want);
  endtask

  // Drop push and hold until every expected word has come back
  task automatic wait_for_results();
    @(negedge clk);
    push = 1'b0;
    while (expected_conversions.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == REG_SOURCE_RADIX) begin
      source_setting = data;
    end else if (idx == REG_TARGET_RADIX) begin
      target_setting = data;
    end
  endtask

  // Write both radices; an unused index goes first and must change nothing
  task automatic set_radices(input logic [RADIX_W-1:0] src, input logic [RADIX_W-1:0] dst);
    logic [CFG_INDEX_W-1:0] stray;
    stray = CFG_INDEX_W'($urandom_range(int'(REG_TARGET_RADIX) + 1, 2**CFG_INDEX_W - 1));
    write_register(stray, CFG_DATA_W'($urandom));
    write_register(REG_SOURCE_RADIX, src);
    write_register(REG_TARGET_RADIX, dst);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: stall at random, then take and check the oldest word
  initial begin : result_side
    int unsigned stall;
    conversion_t want;
    wait (rst == 1'b0);
    forever begin
      stall = burst_phase ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (stall != 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      if (expected_conversions.size() == 0) begin
        report_mismatch("unexpected word", converted_word, '0);
      end else begin
        want = expected_conversions.pop_front();
        if (converted_word !== want.converted) begin
          report_mismatch("converted_word", converted_word, want.converted);
        end
        if (overflow !== want.ovf) begin
          report_mismatch("overflow", RESULT_W'(overflow), RESULT_W'(want.ovf));
        end
      end
    end
  end

  // Watchdog: end the run when no handshake completes for too long
  always @(posedge clk) begin
    if (rst || (push && full === 1'b0) || (pop && empty === 1'b0) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("radix_digit_converter_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    vector_t            row;
    conversion_t        want;
    logic [WORD_W-1:0]  w;
    int unsigned        sent;
    int unsigned        count;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed table; the first rows run on the reset radices
    foreach (directed_vectors[i]) begin
      row = directed_vectors[i];
      if (row.src != source_setting || row.dst != target_setting) begin
        wait_for_results();
        set_radices(row.src, row.dst);
      end
      if (row.known) begin
        want.converted = row.want;
        want.ovf       = row.want_ovf;
      end else begin
        want = convert_radix_digits(row.word, source_setting, target_setting);
      end
      send_word(row.word, want);
    end

    // Random phases, each under its own radix pair
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_for_results();
      set_radices(random_radix_setting(), random_radix_setting());
      burst_phase = ($urandom_range(0, 3) == 0);
      count       = $urandom_range(40, 90);
      for (int i = 0; i < count; i++) begin
        if (i == count / 2 && $urandom_range(0, 3) == 0) begin
          wait_for_results();
        end
        w = random_digit_word(source_setting);
        send_word(w, convert_radix_digits(w, source_setting, target_setting));
      end
      sent += count;
    end

    // Drain, then watch a while for stray words
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("radix_digit_converter_unit regression: pass");
    end else begin
      $display("radix_digit_converter_unit regression: fail");
    end
    $finish;
  end

endmodule
